/* src/drsa_pkg.sv */
// ----------------------------------------------------------------------------
// drsa_pkg
// Shared types and constants for the DER RSA private key parser: beat
// payload structs, DER tag values and parser phase codes.
// ----------------------------------------------------------------------------
`default_nettype none

package drsa_pkg;

    // DER tag and length-form constants
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] LONG_FORM    = 8'h80;

    // parser phase codes
    localparam logic [2:0] PH_OUTER_TAG  = 3'd0;
    localparam logic [2:0] PH_OUTER_LEN  = 3'd1;
    localparam logic [2:0] PH_OUTER_LONG = 3'd2;
    localparam logic [2:0] PH_PART_TAG   = 3'd3;
    localparam logic [2:0] PH_PART_LEN   = 3'd4;
    localparam logic [2:0] PH_PART_LONG  = 3'd5;
    localparam logic [2:0] PH_CONTENT    = 3'd6;
    localparam logic [2:0] PH_IDLE       = 3'd7;

    // latched error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OUTER_TAG = 2'd1;
    localparam logic [1:0] ERR_PART_TAG  = 2'd2;
    localparam logic [1:0] ERR_LEN_LONG  = 2'd3;

    // input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic       content_valid;
        logic [7:0] content_byte;
        logic [3:0] part_index;
        logic       part_last;
        logic       key_done;
        logic [1:0] error_code;
    } t_out_item;

    // narrow control state of the parser
    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] len_left;
        logic [3:0] part;
        logic [1:0] err;
    } t_ctrl;

endpackage

`default_nettype wire

/* src/der_rsa_private_key_parser_core.sv */
// Result: each accepted input beat gives one registered result beat in the cycle after.
// Throughput: one byte per cycle; the parser state updates in a single pass
// per byte, and the result register is refilled whenever it is empty or taken.
// Reset: synchronous, active low; parser returns to expecting the outer tag,
// no error latched, result register empty.
// ----------------------------------------------------------------------------
// der_rsa_private_key_parser_core
// Streaming parser for a DER encoded PKCS#1 RSA private key, one byte per
// beat, tagging each integer content byte with its part index.
// ----------------------------------------------------------------------------
`default_nettype none

module der_rsa_private_key_parser_core #(
    parameter int NUM_PARTS     = 9,
    parameter int MAX_LEN_BYTES = 4
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire drsa_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output drsa_pkg::t_out_item      o_out_data
);

    localparam int ACC_W = 8 * MAX_LEN_BYTES;

    drsa_pkg::t_ctrl      r_ctrl;
    drsa_pkg::t_ctrl      n_ctrl;
    logic [ACC_W-1:0]     r_acc;
    logic [ACC_W-1:0]     n_acc;
    logic [ACC_W-1:0]     r_rem;
    logic [ACC_W-1:0]     n_rem;
    logic                 r_out_valid;
    drsa_pkg::t_out_item  r_out_data;
    drsa_pkg::t_out_item  n_out_data;
    logic                 in_beat;

    // accept while the result register is empty or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_beat    = i_in_valid && o_in_ready;

    drsa_step #(
        .NUM_PARTS     (NUM_PARTS),
        .MAX_LEN_BYTES (MAX_LEN_BYTES)
    ) u_step (
        .i_ctrl   (r_ctrl),
        .i_acc    (r_acc),
        .i_rem    (r_rem),
        .i_item   (i_in_data),
        .o_ctrl   (n_ctrl),
        .o_acc    (n_acc),
        .o_rem    (n_rem),
        .o_result (n_out_data)
    );

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.phase    <= drsa_pkg::PH_OUTER_TAG;
            r_ctrl.len_left <= 3'd0;
            r_ctrl.part     <= 4'd0;
            r_ctrl.err      <= drsa_pkg::ERR_NONE;
            r_acc           <= '0;
            r_rem           <= '0;
        end else if (in_beat) begin
            r_ctrl <= n_ctrl;
            r_acc  <= n_acc;
            r_rem  <= n_rem;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

/* src/drsa_step.sv */
// ----------------------------------------------------------------------------
// drsa_step
// Next-state and result logic for one byte of the DER stream: tag checks,
// short and long length decoding, content tracking and part closing.
// ----------------------------------------------------------------------------
`default_nettype none

module drsa_step #(
    parameter int NUM_PARTS     = 9,
    parameter int MAX_LEN_BYTES = 4
) (
    input  wire drsa_pkg::t_ctrl          i_ctrl,
    input  wire [8*MAX_LEN_BYTES-1:0]     i_acc,
    input  wire [8*MAX_LEN_BYTES-1:0]     i_rem,
    input  wire drsa_pkg::t_in_item       i_item,
    output drsa_pkg::t_ctrl               o_ctrl,
    output logic [8*MAX_LEN_BYTES-1:0]    o_acc,
    output logic [8*MAX_LEN_BYTES-1:0]    o_rem,
    output drsa_pkg::t_out_item           o_result
);

    localparam int ACC_W = 8 * MAX_LEN_BYTES;

    drsa_pkg::t_ctrl    cur;
    logic [ACC_W-1:0]   cur_acc;
    logic [ACC_W-1:0]   cur_rem;
    logic [7:0]         b;
    logic [3:0]         part_inc;
    logic [2:0]         close_phase;
    logic [ACC_W-1:0]   acc_shift;
    logic [2:0]         left_dec;
    logic [ACC_W-1:0]   rem_dec;
    logic               too_long;

    // restart on first byte of a new key
    always_comb begin
        if (i_item.first) begin
            cur.phase    = drsa_pkg::PH_OUTER_TAG;
            cur.len_left = 3'd0;
            cur.part     = 4'd0;
            cur.err      = drsa_pkg::ERR_NONE;
            cur_acc      = '0;
            cur_rem      = '0;
        end else begin
            cur     = i_ctrl;
            cur_acc = i_acc;
            cur_rem = i_rem;
        end
    end

    // shared helper terms
    assign b           = i_item.data_byte;
    assign part_inc    = cur.part + 4'd1;
    assign close_phase = (part_inc >= 4'(NUM_PARTS)) ? drsa_pkg::PH_IDLE
                                                     : drsa_pkg::PH_PART_TAG;
    assign acc_shift   = ACC_W'({cur_acc, b});
    assign left_dec    = cur.len_left - 3'd1;
    assign rem_dec     = cur_rem - ACC_W'(1);
    assign too_long    = b[6:0] > 7'(MAX_LEN_BYTES);

    // phase transitions and result fields
    always_comb begin
        o_ctrl   = cur;
        o_acc    = cur_acc;
        o_rem    = cur_rem;
        o_result = '0;
        case (cur.phase)
            drsa_pkg::PH_OUTER_TAG: begin
                if (b == drsa_pkg::TAG_SEQUENCE) begin
                    o_ctrl.phase = drsa_pkg::PH_OUTER_LEN;
                end else begin
                    o_ctrl.err   = drsa_pkg::ERR_OUTER_TAG;
                    o_ctrl.phase = drsa_pkg::PH_IDLE;
                end
            end
            drsa_pkg::PH_OUTER_LEN, drsa_pkg::PH_PART_LEN: begin
                if (b > drsa_pkg::LONG_FORM) begin
                    if (too_long) begin
                        o_ctrl.err   = drsa_pkg::ERR_LEN_LONG;
                        o_ctrl.phase = drsa_pkg::PH_IDLE;
                    end else begin
                        o_ctrl.len_left = b[2:0];
                        o_acc           = '0;
                        o_ctrl.phase    = (cur.phase == drsa_pkg::PH_OUTER_LEN)
                                          ? drsa_pkg::PH_OUTER_LONG
                                          : drsa_pkg::PH_PART_LONG;
                    end
                end else if (cur.phase == drsa_pkg::PH_OUTER_LEN) begin
                    o_acc        = ACC_W'(b);
                    o_ctrl.phase = drsa_pkg::PH_PART_TAG;
                end else if (b == 8'd0) begin
                    // empty part closes on its length byte
                    o_result.part_last  = 1'b1;
                    o_result.part_index = cur.part;
                    o_ctrl.part         = part_inc;
                    o_ctrl.phase        = close_phase;
                end else begin
                    o_rem        = ACC_W'(b);
                    o_ctrl.phase = drsa_pkg::PH_CONTENT;
                end
            end
            drsa_pkg::PH_OUTER_LONG, drsa_pkg::PH_PART_LONG: begin
                o_acc           = acc_shift;
                o_ctrl.len_left = left_dec;
                if (left_dec == 3'd0) begin
                    if (cur.phase == drsa_pkg::PH_OUTER_LONG) begin
                        o_ctrl.phase = drsa_pkg::PH_PART_TAG;
                    end else if (acc_shift == '0) begin
                        o_result.part_last  = 1'b1;
                        o_result.part_index = cur.part;
                        o_ctrl.part         = part_inc;
                        o_ctrl.phase        = close_phase;
                    end else begin
                        o_rem        = acc_shift;
                        o_ctrl.phase = drsa_pkg::PH_CONTENT;
                    end
                end
            end
            drsa_pkg::PH_PART_TAG: begin
                if (b == drsa_pkg::TAG_INTEGER) begin
                    o_ctrl.phase = drsa_pkg::PH_PART_LEN;
                end else begin
                    o_ctrl.err   = drsa_pkg::ERR_PART_TAG;
                    o_ctrl.phase = drsa_pkg::PH_IDLE;
                end
            end
            drsa_pkg::PH_CONTENT: begin
                o_result.content_valid = 1'b1;
                o_result.content_byte  = b;
                o_result.part_index    = cur.part;
                o_rem                  = rem_dec;
                if (rem_dec == '0) begin
                    o_result.part_last = 1'b1;
                    o_ctrl.part        = part_inc;
                    o_ctrl.phase       = close_phase;
                end
            end
            default: begin
                // idle: bytes ignored until restart
            end
        endcase
        o_result.key_done   = (o_ctrl.phase == drsa_pkg::PH_IDLE) &&
                              (o_ctrl.err == drsa_pkg::ERR_NONE);
        o_result.error_code = o_ctrl.err;
    end

endmodule

`default_nettype wire

/* verif/der_rsa_parser_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// der_rsa_parser_checker
// Watches both beat channels of the DER RSA key parser, predicts the result
// beat for every accepted input byte and compares it with the beat that
// comes out. Hands the failure count and the number of outstanding results
// to the testbench top.
// ----------------------------------------------------------------------------
module der_rsa_parser_checker #(
    parameter int NUM_PARTS     = 9,
    parameter int MAX_LEN_BYTES = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_ready,
    input  drsa_pkg::t_in_item   i_in_data,
    input  wire                  i_out_valid,
    input  wire                  i_out_ready,
    input  drsa_pkg::t_out_item  i_out_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    // predicted parser state
    logic [2:0]  prs_phase;
    logic [2:0]  prs_len_left;
    logic [31:0] prs_len_acc;
    logic [31:0] prs_remaining;
    logic [3:0]  prs_part;
    logic [1:0]  prs_err;

    drsa_pkg::t_out_item awaited_beats[$];
    int                  fail_count = 0;
    int                  pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    function void restart_parser();
        prs_phase     = drsa_pkg::PH_OUTER_TAG;
        prs_len_left  = '0;
        prs_len_acc   = '0;
        prs_remaining = '0;
        prs_part      = '0;
        prs_err       = drsa_pkg::ERR_NONE;
    endfunction

    // step past the current integer; idle once every part is done
    function void close_part();
        prs_part  = prs_part + 4'd1;
        prs_phase = (prs_part >= NUM_PARTS) ? drsa_pkg::PH_IDLE : drsa_pkg::PH_PART_TAG;
    endfunction

    // work out the result beat for one byte and advance the state
    function automatic drsa_pkg::t_out_item parse_byte(input drsa_pkg::t_in_item beat);
        drsa_pkg::t_out_item res;
        logic [7:0]          b;
        logic [7:0]          count;
        res = '0;
        b   = beat.data_byte;
        if (beat.first)
            restart_parser();
        case (prs_phase)
            drsa_pkg::PH_OUTER_TAG: begin
                if (b == drsa_pkg::TAG_SEQUENCE) begin
                    prs_phase = drsa_pkg::PH_OUTER_LEN;
                end else begin
                    prs_err   = drsa_pkg::ERR_OUTER_TAG;
                    prs_phase = drsa_pkg::PH_IDLE;
                end
            end
            drsa_pkg::PH_OUTER_LEN, drsa_pkg::PH_PART_LEN: begin
                if (b > drsa_pkg::LONG_FORM) begin
                    // long form: low bits give the count of length bytes
                    count = b - drsa_pkg::LONG_FORM;
                    if (count > MAX_LEN_BYTES) begin
                        prs_err   = drsa_pkg::ERR_LEN_LONG;
                        prs_phase = drsa_pkg::PH_IDLE;
                    end else begin
                        prs_len_left = count[2:0];
                        prs_len_acc  = '0;
                        prs_phase    = (prs_phase == drsa_pkg::PH_OUTER_LEN)
                                       ? drsa_pkg::PH_OUTER_LONG
                                       : drsa_pkg::PH_PART_LONG;
                    end
                end else if (prs_phase == drsa_pkg::PH_OUTER_LEN) begin
                    prs_len_acc = {24'd0, b};
                    prs_phase   = drsa_pkg::PH_PART_TAG;
                end else if (b == 8'd0) begin
                    res.part_last  = 1'b1;
                    res.part_index = prs_part;
                    close_part();
                end else begin
                    prs_remaining = {24'd0, b};
                    prs_phase     = drsa_pkg::PH_CONTENT;
                end
            end
            drsa_pkg::PH_OUTER_LONG, drsa_pkg::PH_PART_LONG: begin
                // big-endian length bytes
                prs_len_acc  = {prs_len_acc[23:0], b};
                prs_len_left = prs_len_left - 3'd1;
                if (prs_len_left == 3'd0) begin
                    if (prs_phase == drsa_pkg::PH_OUTER_LONG) begin
                        prs_phase = drsa_pkg::PH_PART_TAG;
                    end else if (prs_len_acc == 32'd0) begin
                        res.part_last  = 1'b1;
                        res.part_index = prs_part;
                        close_part();
                    end else begin
                        prs_remaining = prs_len_acc;
                        prs_phase     = drsa_pkg::PH_CONTENT;
                    end
                end
            end
            drsa_pkg::PH_PART_TAG: begin
                if (b == drsa_pkg::TAG_INTEGER) begin
                    prs_phase = drsa_pkg::PH_PART_LEN;
                end else begin
                    prs_err   = drsa_pkg::ERR_PART_TAG;
                    prs_phase = drsa_pkg::PH_IDLE;
                end
            end
            drsa_pkg::PH_CONTENT: begin
                res.content_valid = 1'b1;
                res.content_byte  = b;
                res.part_index    = prs_part;
                prs_remaining     = prs_remaining - 32'd1;
                if (prs_remaining == 32'd0) begin
                    res.part_last = 1'b1;
                    close_part();
                end
            end
            default: ;
        endcase
        res.key_done   = (prs_phase == drsa_pkg::PH_IDLE) && (prs_err == drsa_pkg::ERR_NONE);
        res.error_code = prs_err;
        return res;
    endfunction

    function void note_failure(input string what);
        if (fail_count < 10)
            $display("%0t: %s", $time, what);
        fail_count++;
    endfunction

    // compare result beats first, then queue the prediction for a new byte
    always @(posedge i_clk) begin : check_beats
        drsa_pkg::t_out_item want;
        if (!i_rst_n) begin
            restart_parser();
            awaited_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_beats.size() == 0) begin
                    note_failure("result beat with no byte outstanding");
                end else begin
                    want = awaited_beats.pop_front();
                    if (want !== i_out_data)
                        note_failure({
                            $sformatf("result mismatch: expected valid=%0b byte=%02h part=%0d ",
                                want.content_valid, want.content_byte, want.part_index),
                            $sformatf("last=%0b done=%0b err=%0d, ",
                                want.part_last, want.key_done, want.error_code),
                            $sformatf("got valid=%0b byte=%02h part=%0d ",
                                i_out_data.content_valid, i_out_data.content_byte,
                                i_out_data.part_index),
                            $sformatf("last=%0b done=%0b err=%0d",
                                i_out_data.part_last, i_out_data.key_done,
                                i_out_data.error_code)});
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_beats.push_back(parse_byte(i_in_data));
        end
        pending_cnt = awaited_beats.size();
    end

endmodule

/* verif/tb_der_rsa_private_key_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_der_rsa_private_key_parser_core
// Feeds the DER RSA key parser with a few hand-built streams and then with
// random keys, clean and broken, under bursty input and a stalling
// receiver. Prediction and comparison sit in the checker beside the block.
// ----------------------------------------------------------------------------
module tb_der_rsa_private_key_parser_core;

    localparam int NUM_PARTS     = 9;
    localparam int MAX_LEN_BYTES = 4;
    localparam int RANDOM_BYTES  = 750;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 20;

    // ways a random key stream is spoilt
    typedef enum int {
        KEY_CLEAN,
        BAD_OUTER_TAG,
        BAD_PART_TAG,
        OVERLONG_COUNT,
        HUGE_LENGTH,
        CUT_SHORT
    } t_key_flaw;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    drsa_pkg::t_in_item   in_data   = '0;
    logic                 in_ready;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    drsa_pkg::t_out_item  out_data;
    int                   fail_count;
    int                   pending_results;

    int         burst_left  = 0;
    int         bytes_fed   = 0;
    int         idle_cycles = 0;
    int         ready_mode  = 0;
    int         mode_cycles = 0;
    logic [7:0] key_bytes[$];

    // clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    der_rsa_private_key_parser_core #(
        .NUM_PARTS     (NUM_PARTS),
        .MAX_LEN_BYTES (MAX_LEN_BYTES)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    der_rsa_parser_checker #(
        .NUM_PARTS     (NUM_PARTS),
        .MAX_LEN_BYTES (MAX_LEN_BYTES)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    // receiver: stall pattern switches at random between four ready modes
    always @(negedge clk) begin
        if (mode_cycles == 0) begin
            ready_mode  <= $urandom_range(0, 3);
            mode_cycles <= $urandom_range(20, 120);
        end else begin
            mode_cycles <= mode_cycles - 1;
        end
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= $urandom_range(0, 1);
            default: out_ready <= ~out_ready;
        endcase
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // one byte beat; opens a new burst after a random gap when due
    task automatic send_beat(input logic [7:0] value, input logic restart);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid = 1'b1;
        in_data  = '{data_byte: value, first: restart};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // push out the built stream, first flag on its opening byte if asked
    task automatic send_stream(input logic restart);
        foreach (key_bytes[i])
            send_beat(key_bytes[i], restart && (i == 0));
        bytes_fed += key_bytes.size();
        key_bytes.delete();
    endtask

    // hold the sender until every result beat has come back
    task automatic wait_drained();
        in_valid   = 1'b0;
        burst_left = 0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    initial begin : stimulus
        bit paused;
        paused = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wrong outer tag, then a byte that is ignored
        key_bytes = '{8'h00, 8'hFF};
        send_stream(1'b1);
        // outer length with too many length bytes
        key_bytes = '{drsa_pkg::TAG_SEQUENCE, 8'hFF};
        send_stream(1'b1);
        // full key: 0x80 outer length, one content byte, long-form empty part,
        // then short empty parts, and a trailing byte after completion
        key_bytes = '{drsa_pkg::TAG_SEQUENCE, drsa_pkg::LONG_FORM, drsa_pkg::TAG_INTEGER,
                      8'h01, 8'hFF, drsa_pkg::TAG_INTEGER, 8'h81, 8'h00};
        repeat (NUM_PARTS - 2) begin
            key_bytes.push_back(drsa_pkg::TAG_INTEGER);
            key_bytes.push_back(8'h00);
        end
        key_bytes.push_back(8'h00);
        send_stream(1'b1);

        // random keys, mostly well formed
        while (bytes_fed < RANDOM_BYTES) begin : one_key
            t_key_flaw  flaw;
            int         flaw_part;
            int         part_len;
            int         n_bytes;
            int         pick;
            bit         outer_hit;
            bit         broken;
            logic [7:0] junk;

            flaw      = ($urandom_range(0, 9) < 3) ? t_key_flaw'($urandom_range(1, 5))
                                                   : KEY_CLEAN;
            flaw_part = $urandom_range(0, NUM_PARTS - 1);
            outer_hit = ($urandom_range(0, 3) == 0);
            broken    = 1'b0;

            // outer tag
            if (flaw == BAD_OUTER_TAG) begin
                do junk = 8'($urandom_range(0, 255));
                while (junk == drsa_pkg::TAG_SEQUENCE);
                key_bytes.push_back(junk);
                broken = 1'b1;
            end else begin
                key_bytes.push_back(drsa_pkg::TAG_SEQUENCE);
                // outer length, value never checked
                if (flaw == OVERLONG_COUNT && outer_hit) begin
                    key_bytes.push_back(
                        8'($urandom_range(drsa_pkg::LONG_FORM + MAX_LEN_BYTES + 1, 255)));
                    broken = 1'b1;
                end else if ($urandom_range(0, 1) == 0) begin
                    key_bytes.push_back(8'($urandom_range(0, 128)));
                end else begin
                    n_bytes = $urandom_range(1, MAX_LEN_BYTES);
                    key_bytes.push_back(drsa_pkg::LONG_FORM | 8'(n_bytes));
                    repeat (n_bytes) key_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end

            // integer parts
            for (int p = 0; p < NUM_PARTS && !broken; p++) begin
                if (flaw == BAD_PART_TAG && p == flaw_part) begin
                    do junk = 8'($urandom_range(0, 255));
                    while (junk == drsa_pkg::TAG_INTEGER);
                    key_bytes.push_back(junk);
                    broken = 1'b1;
                end else begin
                    key_bytes.push_back(drsa_pkg::TAG_INTEGER);
                    if (flaw == OVERLONG_COUNT && p == flaw_part) begin
                        key_bytes.push_back(8'($urandom_range(
                            drsa_pkg::LONG_FORM + MAX_LEN_BYTES + 1, 255)));
                        broken = 1'b1;
                    end else if (flaw == HUGE_LENGTH && p == flaw_part) begin
                        // four-byte length far beyond the stream; cut inside content
                        key_bytes.push_back(drsa_pkg::LONG_FORM | 8'(MAX_LEN_BYTES));
                        repeat (MAX_LEN_BYTES) key_bytes.push_back(8'($urandom_range(0, 255)));
                        repeat ($urandom_range(0, 5))
                            key_bytes.push_back(8'($urandom_range(0, 255)));
                        broken = 1'b1;
                    end else begin
                        // mostly tiny parts, now and then a long one
                        pick = $urandom_range(0, 99);
                        if (pick < 80)
                            part_len = $urandom_range(0, 3);
                        else if (pick < 96)
                            part_len = $urandom_range(4, 16);
                        else if (pick < 99)
                            part_len = $urandom_range(17, 60);
                        else
                            part_len = $urandom_range(0, 1) ? 128 : $urandom_range(129, 300);
                        if (part_len <= 128 && $urandom_range(0, 3) != 0) begin
                            key_bytes.push_back(8'(part_len));
                        end else begin
                            n_bytes = $urandom_range(part_len > 255 ? 2 : 1, MAX_LEN_BYTES);
                            key_bytes.push_back(drsa_pkg::LONG_FORM | 8'(n_bytes));
                            for (int i = n_bytes - 1; i >= 0; i--)
                                key_bytes.push_back(8'(part_len >> (8 * i)));
                        end
                        repeat (part_len) key_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                end
            end

            // stream stopped part way, or a little noise after the key
            if (flaw == CUT_SHORT) begin
                n_bytes = $urandom_range(1, key_bytes.size() - 1);
                while (key_bytes.size() > n_bytes) void'(key_bytes.pop_back());
            end else if (broken || $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) key_bytes.push_back(8'($urandom_range(0, 255)));
            end

            // now and then the new key arrives without the first flag
            send_stream($urandom_range(0, 15) != 0);

            if ((!paused && bytes_fed >= RANDOM_BYTES / 2) || $urandom_range(0, 9) == 0) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        // drain and give the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
